// ===== src/acs_pkg.sv =====
// package for the arcoth series evaluator
// sequencer state type, unit start struct, widths, iteration cap and fixed register indexes; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package acs_pkg;
    localparam int unsigned EPS_W   = 25;
    localparam int unsigned ITER_W  = 10;
    localparam logic [ITER_W-1:0] ITER_CAP = 10'd1023;
    localparam logic [0:0] REG_EPS       = 1'b0;
    localparam logic [0:0] REG_MAX_ITERS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQ_W,
        ST_DIV0,
        ST_DIV0_W,
        ST_CHECK,
        ST_POW,
        ST_POW_W,
        ST_SCL,
        ST_SCL_W,
        ST_DIV,
        ST_DIV_W,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic mul_start;
        logic div_start;
    } unit_ctl_t;
endpackage
`default_nettype wire

// ===== src/acs_mul.sv =====
// shared saturating multiplier: (a*b) >> sh, saturated at 2^(DW-1)-1
// computed serially as 16x16 partial products; uses no package items
`timescale 1ns / 1ps
`default_nettype none
module acs_mul #(
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] a,
    input  wire logic [DW-1:0] b,
    input  wire logic [6:0]    sh,
    output logic               done,
    output logic [DW-1:0]      p
);
    // digit count rounded up to a power of two so the digit split is a mask and a shift
    localparam int NC = 1 << $clog2((DW + 15) / 16);
    localparam int PW = 2 * NC * 16;
    localparam int CW = $clog2(NC * NC + 1);
    localparam logic [DW-1:0] MAXMAG = {1'b0, {(DW-1){1'b1}}};

    logic [NC*16-1:0] a_reg, b_reg;
    logic [PW-1:0]    acc_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, fin_reg;
    logic [6:0]       sh_reg;
    logic [DW-1:0]    p_reg;

    logic [CW-1:0] ia, ib;
    logic [15:0]   da, db;
    logic [31:0]   pp;
    logic [PW-1:0] ppx, shifted;

    always_comb
    begin
        ia = cnt_reg % CW'(NC);
        ib = cnt_reg / CW'(NC);
        da = a_reg[ia*16 +: 16];
        db = b_reg[ib*16 +: 16];
        pp = da * db;
        ppx = PW'(pp) << ((ia + ib) * 16);
        shifted = acc_reg >> sh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(NC * NC))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= (NC*16)'(a);
            b_reg   <= (NC*16)'(b);
            sh_reg  <= sh;
            acc_reg <= '0;
        end
        else if (busy_reg && cnt_reg != CW'(NC * NC))
        begin
            acc_reg <= acc_reg + ppx;
        end
        else if (busy_reg)
        begin
            p_reg <= (shifted > PW'(MAXMAG)) ? MAXMAG : shifted[DW-1:0];
        end
    end

    assign done = fin_reg;
    assign p    = p_reg;
endmodule
`default_nettype wire

// ===== src/acs_div.sv =====
// shared restoring divider: floor(2^(2F) / d), saturated at 2^(DW-1)-1
// one quotient bit per cycle; uses no package items
`timescale 1ns / 1ps
`default_nettype none
module acs_div #(
    parameter int DW = 32,
    parameter int FB = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] d,
    output logic               done,
    output logic [DW-1:0]      q
);
    localparam int NB = 2 * FB + 1;
    localparam int BW = $clog2(NB + 1);
    localparam logic [DW-1:0] MAXMAG = {1'b0, {(DW-1){1'b1}}};

    logic [DW:0]   rem_reg;
    logic [DW-1:0] q_reg, d_reg;
    logic [BW-1:0] cnt_reg;
    logic          busy_reg, fin_reg, sat_reg;
    logic [DW:0]   rsh;
    logic [DW:0]   qsh;

    always_comb
    begin
        rsh = {rem_reg[DW-1:0], (cnt_reg == '0)};
        qsh = {q_reg, 1'b0};
        if (rsh >= {1'b0, d_reg})
        begin
            rsh = rsh - {1'b0, d_reg};
            qsh[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= (d != '0);
                fin_reg  <= (d == '0);
            end
            else if (busy_reg && (cnt_reg == BW'(NB - 1) || sat_reg
                                  || qsh > {1'b0, MAXMAG}))
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= d;
            rem_reg <= '0;
            q_reg   <= '0;
            cnt_reg <= '0;
            sat_reg <= (d == '0);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= rsh;
            if (qsh > {1'b0, MAXMAG})
            begin
                sat_reg <= 1'b1;
            end
            q_reg <= qsh[DW-1:0];
        end
    end

    assign done = fin_reg;
    assign q    = sat_reg ? MAXMAG : q_reg;
endmodule
`default_nettype wire

// ===== src/arcoth_series_eval.sv =====
// arcoth series evaluator top level: sequencer around shared multiply and divide
// depends on acs_pkg, acs_mul, acs_div
//
//   channel | signals                        | handshake
//   input   | start, x                       | taken when start && !busy
//   result  | done, sum, iterations, limit_exceeded | one-cycle strobe on done
//   config  | cfg_we, cfg_index, cfg_data    | written when cfg_we
//
// each added term takes two multiplies, one divide and two more states;
// a zero x skips the series and goes straight to the done strobe
// a saturating quotient ends a divide early; the serial divider sets the pace
// reset restores eps=16, max_iters=1000; the result cannot be stalled
`timescale 1ns / 1ps
`default_nettype none
module arcoth_series_eval #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] x,
    output logic                       busy,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      sum,
    output logic [9:0]                 iterations,
    output logic                       limit_exceeded,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [24:0]           cfg_data
);
    localparam int DW = DATA_WIDTH;
    localparam logic [DW-1:0] MAXMAG = {1'b0, {(DW-1){1'b1}}};

    acs_pkg::state_t state_reg, state_next;
    logic [acs_pkg::EPS_W-1:0]  eps_reg;
    logic [acs_pkg::ITER_W-1:0] maxi_reg;
    logic [DW-1:0] xm_reg, x2_reg, pw_reg, term_reg, sum_reg;
    logic          neg_reg, lim_reg, done_reg;
    logic [10:0]   n_reg;

    acs_pkg::unit_ctl_t ctl;
    logic [DW-1:0] ma, mb, mp, dd, dq;
    logic [6:0]    msh;
    logic          mdone, ddone;

    acs_mul #(.DW(DW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(ctl.mul_start),
        .a(ma), .b(mb), .sh(msh), .done(mdone), .p(mp)
    );
    acs_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(ctl.div_start),
        .d(dd), .done(ddone), .q(dq)
    );

    logic [11:0] odd;
    logic [DW:0] sum_add;
    assign odd     = {n_reg, 1'b1};
    assign sum_add = {1'b0, sum_reg} + {1'b0, term_reg};

    always_comb
    begin
        state_next    = state_reg;
        ctl.mul_start = 1'b0;
        ctl.div_start = 1'b0;
        ma  = xm_reg;
        mb  = xm_reg;
        msh = 7'(FRAC_BITS);
        dd  = xm_reg;
        case (state_reg)
            acs_pkg::ST_IDLE:   if (start && !busy) state_next = acs_pkg::ST_SQ;
            acs_pkg::ST_SQ:
            begin
                if (xm_reg == '0)
                begin
                    state_next = acs_pkg::ST_DONE;
                end
                else
                begin
                    ctl.mul_start = 1'b1;
                    state_next = acs_pkg::ST_SQ_W;
                end
            end
            acs_pkg::ST_SQ_W:   if (mdone) state_next = acs_pkg::ST_DIV0;
            acs_pkg::ST_DIV0:
            begin
                ctl.div_start = 1'b1;
                state_next = acs_pkg::ST_DIV0_W;
            end
            acs_pkg::ST_DIV0_W: if (ddone) state_next = acs_pkg::ST_CHECK;
            acs_pkg::ST_CHECK:
            begin
                if (term_reg > DW'(eps_reg) && !lim_reg)
                    state_next = acs_pkg::ST_POW;
                else
                    state_next = acs_pkg::ST_DONE;
            end
            acs_pkg::ST_POW:
            begin
                ma = pw_reg;
                mb = x2_reg;
                ctl.mul_start = 1'b1;
                state_next = acs_pkg::ST_POW_W;
            end
            acs_pkg::ST_POW_W:  if (mdone) state_next = acs_pkg::ST_SCL;
            acs_pkg::ST_SCL:
            begin
                ma  = pw_reg;
                mb  = DW'(odd);
                msh = '0;
                ctl.mul_start = 1'b1;
                state_next = acs_pkg::ST_SCL_W;
            end
            acs_pkg::ST_SCL_W:  if (mdone) state_next = acs_pkg::ST_DIV;
            acs_pkg::ST_DIV:
            begin
                dd = mp;
                ctl.div_start = 1'b1;
                state_next = acs_pkg::ST_DIV_W;
            end
            acs_pkg::ST_DIV_W:  if (ddone) state_next = acs_pkg::ST_ACC;
            acs_pkg::ST_ACC:    state_next = acs_pkg::ST_CHECK;
            acs_pkg::ST_DONE:   state_next = acs_pkg::ST_IDLE;
            default:            state_next = acs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acs_pkg::ST_IDLE;
            eps_reg   <= 25'd16;
            maxi_reg  <= 10'd1000;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == acs_pkg::ST_DONE);
            if (cfg_we)
            begin
                if (cfg_index == acs_pkg::REG_EPS)
                    eps_reg <= cfg_data;
                else
                    maxi_reg <= cfg_data[9:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            acs_pkg::ST_IDLE:
            begin
                neg_reg <= x[DW-1];
                xm_reg  <= x[DW-1] ? (~x + 1'b1) : x;
                lim_reg <= 1'b0;
                n_reg   <= 11'd1;
            end
            acs_pkg::ST_SQ:
            begin
                if (xm_reg == '0)
                begin
                    sum_reg <= MAXMAG;
                    lim_reg <= 1'b1;
                    n_reg   <= 11'(maxi_reg) + 11'd1;
                end
                pw_reg <= xm_reg;
            end
            acs_pkg::ST_SQ_W:  if (mdone) x2_reg <= mp;
            acs_pkg::ST_DIV0_W:
            begin
                if (ddone)
                begin
                    term_reg <= dq;
                    sum_reg  <= dq;
                end
            end
            acs_pkg::ST_POW_W: if (mdone) pw_reg <= mp;
            acs_pkg::ST_DIV_W: if (ddone) term_reg <= dq;
            acs_pkg::ST_ACC:
            begin
                sum_reg <= (sum_add > {1'b0, MAXMAG}) ? MAXMAG : sum_add[DW-1:0];
                n_reg   <= n_reg + 11'd1;
                lim_reg <= (n_reg + 11'd1) > 11'(maxi_reg);
            end
            acs_pkg::ST_DONE:
            begin
                sum            <= neg_reg ? (~sum_reg + 1'b1) : sum_reg;
                iterations     <= (n_reg > 11'(acs_pkg::ITER_CAP)) ? acs_pkg::ITER_CAP
                                                                  : n_reg[9:0];
                // a zero limit is already passed by the first term
                limit_exceeded <= (n_reg > 11'(maxi_reg));
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != acs_pkg::ST_IDLE);
    assign done = done_reg;

`ifndef ASSERT_OFF
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == acs_pkg::ST_DONE)) else $error("stray done");
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.mul_start && ctl.div_start)) else $error("both units started");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
`endif
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for arcoth_series_eval: directed and random arguments
// across several eps / max_iters settings, each result checked against a local predictor
// depends on acs_pkg and the arcoth_series_eval rtl
`timescale 1ns / 1ps
module testbench;
    localparam int DW = 32;
    localparam int FB = 24;
    localparam logic [63:0] MAXMAG = 64'h7fff_ffff;
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef struct {
        logic [DW-1:0] sum;
        logic [9:0]    iterations;
        logic          limit_exceeded;
    } arcoth_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [DW-1:0] x = '0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [24:0] cfg_data = '0;
    logic busy, done, limit_exceeded;
    logic [DW-1:0] sum;
    logic [9:0] iterations;

    logic [24:0] eps_q = 25'd16;
    logic [9:0] max_iters_q = 10'd1000;
    arcoth_res_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 0;

    arcoth_series_eval dut (
        .clk(clk), .rst_n(rst_n), .start(start), .x(x), .busy(busy), .done(done),
        .sum(sum), .iterations(iterations), .limit_exceeded(limit_exceeded),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p > {64'd0, MAXMAG}) ? MAXMAG : p[63:0];
    endfunction

    function automatic logic [63:0] recip_sat(logic [63:0] d);
        logic [63:0] q;
        if (d == 0)
            return MAXMAG;
        q = (64'd1 << (2 * FB)) / d;
        return (q > MAXMAG) ? MAXMAG : q;
    endfunction

    function automatic arcoth_res_t predict_arcoth(logic [DW-1:0] arg);
        arcoth_res_t r;
        logic neg;
        logic [63:0] xm, x2, pw, term, acc, n;
        logic [DW-1:0] mag;
        neg = arg[DW-1];
        mag = -arg;
        xm = neg ? {32'd0, mag} : {32'd0, arg};
        if (neg && arg == 32'h8000_0000)
            xm = 64'h8000_0000;
        if (xm == 0)
        begin
            n = max_iters_q + 64'd1;
            acc = MAXMAG;
            r.limit_exceeded = 1'b1;
        end
        else
        begin
            x2 = mul_sat(xm, xm, FB);
            pw = xm;
            n = 1;
            term = recip_sat(xm);
            acc = term;
            while (term > eps_q)
            begin
                pw = mul_sat(pw, x2, FB);
                term = recip_sat(mul_sat(pw, 2 * n + 1, 0));
                acc = (acc > MAXMAG - term) ? MAXMAG : acc + term;
                n++;
                if (n > max_iters_q)
                    break;
            end
            r.limit_exceeded = n > max_iters_q;
        end
        if (n > acs_pkg::ITER_CAP)
            n = acs_pkg::ITER_CAP;
        r.sum = neg ? -acc[DW-1:0] : acc[DW-1:0];
        r.iterations = n[9:0];
        return r;
    endfunction

    // results cannot be held off, so every strobe is checked at once
    always @(posedge clk)
    begin
        arcoth_res_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result sum=%h", sum);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (sum !== e.sum)
                begin
                    $error("sum expected %h actual %h", e.sum, sum);
                    errors++;
                end
                if (iterations !== e.iterations)
                begin
                    $error("iterations expected %0d actual %0d", e.iterations, iterations);
                    errors++;
                end
                if (limit_exceeded !== e.limit_exceeded)
                begin
                    $error("limit_exceeded expected %b actual %b",
                           e.limit_exceeded, limit_exceeded);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(logic [DW-1:0] arg);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        x = arg;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_results.push_back(predict_arcoth(arg));
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain;
        wait (pending_results.size() == 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [24:0] val);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == acs_pkg::REG_EPS)
            eps_q = val;
        else
            max_iters_q = val[9:0];
    endtask

    task automatic set_config(logic [24:0] e, logic [9:0] m);
        write_reg(acs_pkg::REG_EPS, e);
        write_reg(acs_pkg::REG_MAX_ITERS, {15'd0, m});
    endtask

    task automatic test_defaults;
        send_item(32'h0300_0000);
        send_item(32'hfd00_0000);
        send_item(32'h7fff_ffff);
        send_item(32'h8000_0000);
        send_item(32'h0000_0000);
    endtask

    task automatic test_directed_edges;
        set_config(25'd16, 10'd30);
        send_item(32'h0100_0000);
        send_item(32'hff00_0000);
        send_item(32'h0080_0000);
        send_item(32'h0000_0001);
        send_item(32'hffff_ffff);
        send_item(32'h0200_0000);
        send_item(32'h0180_0000);
        set_config(25'd16777216, 10'd1);
        send_item(32'h0200_0000);
        send_item(32'h0100_0000);
        send_item(32'h0000_0000);
        set_config(25'd1, 10'd0);
        send_item(32'h0400_0000);
        send_item(32'h7fff_ffff);
        send_item(32'h0000_0000);
        // zero argument with the largest limit hits the iteration cap
        set_config(25'd1, 10'd1023);
        send_item(32'h0000_0000);
        send_item(32'h7000_0000);
        // argument of one never converges, full run to the limit
        set_config(25'd1, 10'd1000);
        send_item(32'h0100_0000);
    endtask

    task automatic test_random_phase(int pct, int count);
        logic [24:0] e;
        logic [31:0] arg;
        idle_pct = pct;
        case ($urandom_range(3))
            0: e = 25'd1;
            1: e = 25'd16;
            2: e = 25'd16777216;
            default: e = 25'($urandom_range(25'd16777216, 1));
        endcase
        set_config(e, 10'($urandom_range(40, 1)));
        repeat (count)
        begin
            arg = $urandom;
            // mostly arguments with magnitude near one to a few
            if ($urandom_range(99) < 60)
            begin
                arg = $urandom_range(32'h0500_0000, 32'h0040_0000);
                if ($urandom_range(1))
                    arg = -arg;
            end
            send_item(arg);
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        test_defaults();
        test_directed_edges();
        test_random_phase(0, 20);
        test_random_phase(55, 20);
        test_random_phase(21, 20);
        test_random_phase(0, 20);
        drain();
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

// ===== files.f =====
src/acs_pkg.sv
src/acs_mul.sv
src/acs_div.sv
src/arcoth_series_eval.sv
tb/testbench.sv
